>>> rtl/state_variable_filter_multimode_assert.svh
// Assertion macros used by the filter checker.
`ifndef STATE_VARIABLE_FILTER_MULTIMODE_ASSERT_SVH
`define STATE_VARIABLE_FILTER_MULTIMODE_ASSERT_SVH

// checked on every clock edge outside reset
`define SVF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// checked on every clock edge, reset included
`define SVF_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

>>> rtl/svf_pkg.sv
// Shared types, constants and saturation helper for the state-variable filter.
package svf_pkg;

   localparam int ACC_W      = 32;
   localparam int COEF_W     = 26;
   localparam int DIGIT_W    = 2;
   localparam int PROD_W     = ACC_W + COEF_W;
   localparam int SHIFT_MIN  = 18;
   localparam int RND_W      = PROD_W - SHIFT_MIN;
   localparam int SUM_W      = RND_W + 2;
   localparam int COEF_FRAC  = 20;
   localparam int RECIP_FRAC = 24;
   localparam int GAIN_W     = 24;
   localparam int RECIP_W    = 25;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 25;

   typedef logic signed [ACC_W-1:0]  acc_type;
   typedef logic [COEF_W-1:0]        coef_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [RND_W-1:0]  rnd_type;
   typedef logic signed [SUM_W-1:0]  sum_type;
   typedef logic [GAIN_W-1:0]        gain_type;
   typedef logic [RECIP_W-1:0]       recip_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN    = 2'd0,
      CSR_DAMPING = 2'd1,
      CSR_RECIP   = 2'd2
   } csr_index_type;

   localparam gain_type  GAIN_RESET  = 24'h10_0000;
   localparam gain_type  DAMP_RESET  = 24'h10_0000;
   localparam recip_type RECIP_RESET = 25'h040_0000;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_stat_type;

   typedef struct packed {
      logic start;
      logic out_free;
   } core_ctl_type;

   typedef struct packed {
      logic idle;
      logic done;
   } core_stat_type;

   localparam sum_type ACC_HI = sum_type'(32'sh7FFF_FFFF);
   localparam sum_type ACC_LO = ~ACC_HI;

   function automatic acc_type sat_acc(input sum_type v);
      acc_type r;
      priority if (v > ACC_HI) begin
         r = ACC_HI[ACC_W-1:0];
      end else if (v < ACC_LO) begin
         r = ACC_LO[ACC_W-1:0];
      end else begin
         r = v[ACC_W-1:0];
      end
      return r;
   endfunction

endpackage

>>> rtl/svf_channels.sv
// Handshake channel interfaces: sample input, response output, register write.
interface svf_req_if #(
   parameter int SAMPLE_BITS = 24
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] audio_in;

   modport source (output valid, output audio_in, input ready);
   modport sink (input valid, input audio_in, output ready);
endinterface

interface svf_rsp_if #(
   parameter int SAMPLE_BITS = 24
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] lowpass_out;
   logic signed [SAMPLE_BITS-1:0] highpass_out;
   logic signed [SAMPLE_BITS-1:0] bandpass_out;
   logic signed [SAMPLE_BITS-1:0] allpass_out;
   logic signed [SAMPLE_BITS-1:0] notch_out;
   logic signed [SAMPLE_BITS-1:0] peak_out;

   modport source (output valid, output lowpass_out, output highpass_out,
                   output bandpass_out, output allpass_out, output notch_out,
                   output peak_out, input ready);
   modport sink (input valid, input lowpass_out, input highpass_out,
                 input bandpass_out, input allpass_out, input notch_out,
                 input peak_out, output ready);
endinterface

interface svf_csr_if;
   logic                             valid;
   logic                             ready;
   logic [svf_pkg::CSR_IDX_W-1:0]    index;
   logic [svf_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/svf_mul.sv
// Radix-4 digit-serial multiplier: signed 32-bit signal times unsigned coefficient.
module svf_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  svf_pkg::acc_type      sig,
   input  svf_pkg::coef_type     coef,
   output svf_pkg::prod_type     prod,
   output svf_pkg::mul_stat_type stat
);

   localparam int DIGITS = svf_pkg::COEF_W / svf_pkg::DIGIT_W;
   localparam int CNT_W  = $clog2(DIGITS + 1);
   localparam int PART_W = svf_pkg::ACC_W + svf_pkg::DIGIT_W;

   typedef logic signed [PART_W-1:0] part_type;

   part_type                     one_ff, one_in;
   part_type                     tri_ff, tri_in;
   part_type                     pp;
   svf_pkg::coef_type            coef_ff, coef_in;
   svf_pkg::prod_type            acc_ff, acc_in, acc_step;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [svf_pkg::DIGIT_W-1:0]  digit;

   // top digit of the coefficient shift register selects the partial product
   assign digit = coef_ff[svf_pkg::COEF_W-1 -: svf_pkg::DIGIT_W];

   always_comb begin
      unique case (digit)
         2'd0:    pp = '0;
         2'd1:    pp = one_ff;
         2'd2:    pp = one_ff <<< 1;
         2'd3:    pp = tri_ff;
         default: pp = '0;
      endcase
      acc_step = (acc_ff <<< svf_pkg::DIGIT_W) + svf_pkg::prod_type'(pp);
   end

   always_comb begin
      one_in  = one_ff;
      tri_in  = tri_ff;
      coef_in = coef_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         one_in  = part_type'(sig);
         tri_in  = part_type'(sig) + (part_type'(sig) <<< 1);
         coef_in = coef;
         acc_in  = '0;
         cnt_in  = CNT_W'(DIGITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in  = acc_step;
         coef_in = coef_ff << svf_pkg::DIGIT_W;
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      one_ff  <= one_in;
      tri_ff  <= tri_in;
      coef_ff <= coef_in;
      acc_ff  <= acc_in;
   end

   assign prod = acc_ff;

   always_comb begin
      stat.busy = busy_ff;
      stat.done = done_ff;
   end

endmodule

>>> rtl/svf_core.sv
// Filter sequencer: integrator states, rounding, saturation and response outputs.
module svf_core #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  svf_pkg::core_ctl_type         ctl,
   input  logic signed [SAMPLE_BITS-1:0] audio,
   input  svf_pkg::gain_type             gain,
   input  svf_pkg::gain_type             damping,
   input  svf_pkg::recip_type            recip,
   output svf_pkg::core_stat_type        stat,
   output logic signed [SAMPLE_BITS-1:0] lowpass,
   output logic signed [SAMPLE_BITS-1:0] highpass,
   output logic signed [SAMPLE_BITS-1:0] bandpass,
   output logic signed [SAMPLE_BITS-1:0] allpass,
   output logic signed [SAMPLE_BITS-1:0] notch,
   output logic signed [SAMPLE_BITS-1:0] peak
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b000_0001,
      ST_ISSUE = 7'b000_0010,
      ST_MUL   = 7'b000_0100,
      ST_RND   = 7'b000_1000,
      ST_POST  = 7'b001_0000,
      ST_POST2 = 7'b010_0000,
      ST_FIN   = 7'b100_0000
   } state_type;

   // multiply order within one sample
   typedef enum logic [2:0] {
      OP_DAMP,
      OP_NORM,
      OP_BAND,
      OP_LOW,
      OP_TAP
   } op_type;

   typedef logic signed [svf_pkg::ACC_W:0]  xs_type;
   typedef logic signed [svf_pkg::PROD_W:0] rsum_type;

   localparam logic [4:0] SH_COEF  = 5'(svf_pkg::COEF_FRAC);
   localparam logic [4:0] SH_RECIP = 5'(svf_pkg::RECIP_FRAC);
   localparam logic [4:0] SH_UBP   = 5'(svf_pkg::COEF_FRAC - 1);
   localparam logic [4:0] SH_WIDE  = 5'(svf_pkg::COEF_FRAC - 2);

   localparam svf_pkg::sum_type OUT_HI =
      (svf_pkg::sum_type'(1) <<< (SAMPLE_BITS - 1)) - svf_pkg::sum_type'(1);
   localparam svf_pkg::sum_type OUT_LO = ~OUT_HI;

   function automatic logic signed [SAMPLE_BITS-1:0] sat_out(input svf_pkg::sum_type v);
      logic signed [SAMPLE_BITS-1:0] r;
      priority if (v > OUT_HI) begin
         r = OUT_HI[SAMPLE_BITS-1:0];
      end else if (v < OUT_LO) begin
         r = OUT_LO[SAMPLE_BITS-1:0];
      end else begin
         r = v[SAMPLE_BITS-1:0];
      end
      return r;
   endfunction

   state_type                     state_ff, state_in;
   op_type                        op_ff, op_in, op_next;
   logic signed [SAMPLE_BITS-1:0] x_ff, x_in;
   xs_type                        xs_ff, xs_in;
   svf_pkg::coef_type             c_ff, c_in;
   svf_pkg::rnd_type              r_ff, r_in, w_ff, w_in, rnd_val;
   svf_pkg::acc_type              t_ff, t_in, hp_ff, hp_in, bp_ff, bp_in, lp_ff, lp_in;
   svf_pkg::acc_type              s1_ff, s1_in, s2_ff, s2_in;
   logic                          mul_start;
   svf_pkg::acc_type              mul_sig;
   svf_pkg::coef_type             mul_coef;
   svf_pkg::prod_type             mul_prod;
   svf_pkg::mul_stat_type         mul_stat;
   logic [4:0]                    rnd_sh;
   rsum_type                      rnd_half, rnd_sum, rnd_shift;

   svf_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .sig   (mul_sig),
      .coef  (mul_coef),
      .prod  (mul_prod),
      .stat  (mul_stat)
   );

   always_comb begin
      unique case (op_ff)
         OP_DAMP: begin
            mul_sig  = s1_ff;
            mul_coef = c_ff;
         end
         OP_NORM: begin
            mul_sig  = t_ff;
            mul_coef = svf_pkg::coef_type'(recip);
         end
         OP_BAND: begin
            mul_sig  = hp_ff;
            mul_coef = svf_pkg::coef_type'(gain);
         end
         OP_LOW: begin
            mul_sig  = bp_ff;
            mul_coef = svf_pkg::coef_type'(gain);
         end
         OP_TAP: begin
            mul_sig  = bp_ff;
            mul_coef = svf_pkg::coef_type'(damping);
         end
         default: begin
            mul_sig  = s1_ff;
            mul_coef = c_ff;
         end
      endcase
   end

   // bp*R product: 2R*bp rounds at one bit less, 4R*bp at two bits less
   always_comb begin
      priority if (state_ff == ST_POST) begin
         rnd_sh = SH_WIDE;
      end else if (op_ff == OP_NORM) begin
         rnd_sh = SH_RECIP;
      end else if (op_ff == OP_TAP) begin
         rnd_sh = SH_UBP;
      end else begin
         rnd_sh = SH_COEF;
      end
      rnd_half  = rsum_type'(1) <<< (rnd_sh - 5'd1);
      rnd_sum   = rsum_type'(mul_prod) + rnd_half;
      rnd_shift = rnd_sum >>> rnd_sh;
      rnd_val   = rnd_shift[svf_pkg::RND_W-1:0];
   end

   always_comb begin
      unique case (op_ff)
         OP_DAMP: op_next = OP_NORM;
         OP_NORM: op_next = OP_BAND;
         OP_BAND: op_next = OP_LOW;
         OP_LOW:  op_next = OP_TAP;
         default: op_next = OP_DAMP;
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      x_in      = x_ff;
      xs_in     = xs_ff;
      c_in      = c_ff;
      r_in      = r_ff;
      w_in      = w_ff;
      t_in      = t_ff;
      hp_in     = hp_ff;
      bp_in     = bp_ff;
      lp_in     = lp_ff;
      s1_in     = s1_ff;
      s2_in     = s2_ff;
      mul_start = 1'b0;
      stat      = '0;
      stat.idle = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (ctl.start) begin
               x_in     = audio;
               xs_in    = xs_type'(audio) - xs_type'(s2_ff);
               c_in     = svf_pkg::coef_type'({damping, 1'b0}) + svf_pkg::coef_type'(gain);
               op_in    = OP_DAMP;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (!mul_stat.busy) begin
               mul_start = 1'b1;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mul_stat.done) begin
               state_in = ST_RND;
            end
         end
         ST_RND: begin
            r_in     = rnd_val;
            state_in = ST_POST;
         end
         ST_POST: begin
            op_in    = op_next;
            state_in = ST_ISSUE;
            unique case (op_ff)
               OP_DAMP: begin
                  t_in = svf_pkg::sat_acc(svf_pkg::sum_type'(xs_ff) - svf_pkg::sum_type'(r_ff));
               end
               OP_NORM: begin
                  hp_in = svf_pkg::sat_acc(svf_pkg::sum_type'(r_ff));
               end
               OP_BAND: begin
                  bp_in    = svf_pkg::sat_acc(svf_pkg::sum_type'(r_ff) +
                                              svf_pkg::sum_type'(s1_ff));
                  op_in    = op_ff;
                  state_in = ST_POST2;
               end
               OP_LOW: begin
                  lp_in    = svf_pkg::sat_acc(svf_pkg::sum_type'(r_ff) +
                                              svf_pkg::sum_type'(s2_ff));
                  op_in    = op_ff;
                  state_in = ST_POST2;
               end
               OP_TAP: begin
                  w_in     = rnd_val;
                  op_in    = op_ff;
                  state_in = ST_FIN;
               end
               default: ;
            endcase
         end
         ST_POST2: begin
            op_in    = op_next;
            state_in = ST_ISSUE;
            if (op_ff == OP_BAND) begin
               s1_in = svf_pkg::sat_acc(svf_pkg::sum_type'(r_ff) + svf_pkg::sum_type'(bp_ff));
            end else begin
               s2_in = svf_pkg::sat_acc(svf_pkg::sum_type'(r_ff) + svf_pkg::sum_type'(lp_ff));
            end
         end
         ST_FIN: begin
            if (ctl.out_free) begin
               stat.done = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_DAMP;
         s1_ff    <= '0;
         s2_ff    <= '0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         s1_ff    <= s1_in;
         s2_ff    <= s2_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff  <= x_in;
      xs_ff <= xs_in;
      c_ff  <= c_in;
      r_ff  <= r_in;
      w_ff  <= w_in;
      t_ff  <= t_in;
      hp_ff <= hp_in;
      bp_ff <= bp_in;
      lp_ff <= lp_in;
   end

   // r_ff holds 2R*bp and w_ff holds 4R*bp once the last multiply is done
   assign lowpass  = sat_out(svf_pkg::sum_type'(lp_ff));
   assign highpass = sat_out(svf_pkg::sum_type'(hp_ff));
   assign bandpass = sat_out(svf_pkg::sum_type'(r_ff));
   assign allpass  = sat_out(svf_pkg::sum_type'(x_ff) - svf_pkg::sum_type'(w_ff));
   assign notch    = sat_out(svf_pkg::sum_type'(x_ff) - svf_pkg::sum_type'(r_ff));
   assign peak     = sat_out(svf_pkg::sum_type'(lp_ff) - svf_pkg::sum_type'(hp_ff));

endmodule

>>> rtl/state_variable_filter_multimode.sv
// Top level of the multimode state-variable filter: register file, core and response register.
// Response: rsp valid is registered from the core's done strobe after all five multiplies, if the response
//    register is free by then; otherwise the core holds in its final step until it is.
// Flow: a new req beat is taken only once the core is idle again, as five 13-digit radix-4 multiplies
//    that share one serial multiplier; req is taken while a response waits.
// Reset: clears both integrators and the handshakes, loads g = 1.0, R = 1.0, recip = 0.25.
module state_variable_filter_multimode #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic       clock,
   input  logic       reset,
   svf_req_if.sink    req_chan,
   svf_rsp_if.source  rsp_chan,
   svf_csr_if.sink    csr_chan
);

   svf_pkg::gain_type             gain_ff, gain_in;
   svf_pkg::gain_type             damp_ff, damp_in;
   svf_pkg::recip_type            recip_ff, recip_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] lp_ff, hp_ff, bp_ff, ap_ff, notch_ff, peak_ff;
   logic signed [SAMPLE_BITS-1:0] core_lp, core_hp, core_bp, core_ap, core_notch, core_peak;
   svf_pkg::core_ctl_type         core_ctl;
   svf_pkg::core_stat_type        core_stat;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      gain_in  = gain_ff;
      damp_in  = damp_ff;
      recip_in = recip_ff;
      if (csr_chan.valid && csr_chan.ready) begin
         unique case (csr_chan.index)
            svf_pkg::CSR_GAIN:    gain_in  = csr_chan.data[svf_pkg::GAIN_W-1:0];
            svf_pkg::CSR_DAMPING: damp_in  = csr_chan.data[svf_pkg::GAIN_W-1:0];
            svf_pkg::CSR_RECIP:   recip_in = csr_chan.data[svf_pkg::RECIP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= svf_pkg::GAIN_RESET;
         damp_ff  <= svf_pkg::DAMP_RESET;
         recip_ff <= svf_pkg::RECIP_RESET;
      end else begin
         gain_ff  <= gain_in;
         damp_ff  <= damp_in;
         recip_ff <= recip_in;
      end
   end

   assign req_chan.ready    = core_stat.idle;
   assign core_ctl.start    = req_chan.valid && req_chan.ready;
   assign core_ctl.out_free = !rsp_valid_ff || rsp_chan.ready;

   svf_core #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .ctl      (core_ctl),
      .audio    (req_chan.audio_in),
      .gain     (gain_ff),
      .damping  (damp_ff),
      .recip    (recip_ff),
      .stat     (core_stat),
      .lowpass  (core_lp),
      .highpass (core_hp),
      .bandpass (core_bp),
      .allpass  (core_ap),
      .notch    (core_notch),
      .peak     (core_peak)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (core_stat.done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (core_stat.done) begin
         lp_ff    <= core_lp;
         hp_ff    <= core_hp;
         bp_ff    <= core_bp;
         ap_ff    <= core_ap;
         notch_ff <= core_notch;
         peak_ff  <= core_peak;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.lowpass_out  = lp_ff;
   assign rsp_chan.highpass_out = hp_ff;
   assign rsp_chan.bandpass_out = bp_ff;
   assign rsp_chan.allpass_out  = ap_ff;
   assign rsp_chan.notch_out    = notch_ff;
   assign rsp_chan.peak_out     = peak_ff;

endmodule

>>> rtl/svf_checker.sv
// Port-level checker for the state-variable filter and its bind to the top level.
`include "state_variable_filter_multimode_assert.svh"

module svf_checker #(
   parameter int SAMPLE_BITS = 24
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [SAMPLE_BITS-1:0] lowpass_out,
   input logic signed [SAMPLE_BITS-1:0] highpass_out,
   input logic signed [SAMPLE_BITS-1:0] bandpass_out,
   input logic signed [SAMPLE_BITS-1:0] allpass_out,
   input logic signed [SAMPLE_BITS-1:0] notch_out,
   input logic signed [SAMPLE_BITS-1:0] peak_out
);

   logic                     rsp_stall;
   logic [6*SAMPLE_BITS-1:0] rsp_payload;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_payload = {lowpass_out, highpass_out, bandpass_out, allpass_out, notch_out,
                         peak_out};

   // a stalled response beat keeps its payload
   `SVF_ASSERT(a_rsp_hold, rsp_stall |=> rsp_valid && $stable(rsp_payload), "rsp beat not held")

   // one sample in flight
   `SVF_ASSERT(a_one_in_flight, req_valid && req_ready |=> !req_ready, "req taken again right after a beat")

   `SVF_ASSERT(a_ready_after_reset, $fell(reset) |-> req_ready, "core not idle after reset")

   `SVF_ASSERT_RST(a_reset_clears_rsp, reset |=> !rsp_valid, "response valid after reset")

endmodule

bind state_variable_filter_multimode svf_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_svf_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .lowpass_out  (rsp_chan.lowpass_out),
   .highpass_out (rsp_chan.highpass_out),
   .bandpass_out (rsp_chan.bandpass_out),
   .allpass_out  (rsp_chan.allpass_out),
   .notch_out    (rsp_chan.notch_out),
   .peak_out     (rsp_chan.peak_out)
);

>>> bench/state_variable_filter_multimode_tb.sv
// Self-checking testbench for the multimode state-variable filter: checks all six responses.
module state_variable_filter_multimode_tb;

   localparam int SAMPLE_W = 24;
   localparam logic [svf_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7F_FFFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh80_0000;
   localparam svf_pkg::gain_type GAIN_MAX = 24'hFF_FFFF;
   localparam svf_pkg::recip_type RECIP_MAX = 25'h1FF_FFFF;
   localparam svf_pkg::recip_type RECIP_ONE = 25'h100_0000;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_BEATS = 95;
   localparam int LONG_HOLD_CYCLES = 600;
   localparam int SETTLE_CYCLES = 100;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] lowpass;
      logic signed [SAMPLE_W-1:0] highpass;
      logic signed [SAMPLE_W-1:0] bandpass;
      logic signed [SAMPLE_W-1:0] allpass;
      logic signed [SAMPLE_W-1:0] notch;
      logic signed [SAMPLE_W-1:0] peak;
   } filter_response_type;

   // floor(v / 2^s + 1/2)
   function automatic longint scale_round(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clip(longint v, int bits);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         return hi;
      end
      if (v < lo) begin
         return lo;
      end
      return v;
   endfunction

   class svf_expected_responses;
      bit [svf_pkg::GAIN_W-1:0]  gain;
      bit [svf_pkg::GAIN_W-1:0]  damping;
      bit [svf_pkg::RECIP_W-1:0] recip;
      longint band_state;
      longint low_state;
      filter_response_type pending[$];
      int unsigned mismatches;
      int unsigned samples_taken;
      int unsigned responses_checked;

      function new();
         gain = svf_pkg::GAIN_RESET;
         damping = svf_pkg::DAMP_RESET;
         recip = svf_pkg::RECIP_RESET;
         band_state = 0;
         low_state = 0;
         mismatches = 0;
         samples_taken = 0;
         responses_checked = 0;
      endfunction

      function void write_register(logic [svf_pkg::CSR_IDX_W-1:0] idx,
                                   logic [svf_pkg::CSR_DATA_W-1:0] value);
         case (idx)
            svf_pkg::CSR_GAIN: gain = value[svf_pkg::GAIN_W-1:0];
            svf_pkg::CSR_DAMPING: damping = value[svf_pkg::GAIN_W-1:0];
            svf_pkg::CSR_RECIP: recip = value[svf_pkg::RECIP_W-1:0];
            default: ;
         endcase
      endfunction

      function void accept_sample(logic signed [SAMPLE_W-1:0] sample);
         longint x, g, two_r, four_r, t, hp, bp, lp, ubp, wide_bp, g_hp, g_bp;
         filter_response_type r;
         x = longint'(sample);
         g = longint'(gain);
         two_r = longint'(damping) <<< 1;
         four_r = longint'(damping) <<< 2;
         t = clip(x - scale_round(band_state * (two_r + g), svf_pkg::COEF_FRAC) - low_state,
                  svf_pkg::ACC_W);
         hp = clip(scale_round(t * longint'(recip), svf_pkg::RECIP_FRAC), svf_pkg::ACC_W);
         g_hp = scale_round(hp * g, svf_pkg::COEF_FRAC);
         bp = clip(g_hp + band_state, svf_pkg::ACC_W);
         g_bp = scale_round(bp * g, svf_pkg::COEF_FRAC);
         lp = clip(g_bp + low_state, svf_pkg::ACC_W);
         ubp = scale_round(bp * two_r, svf_pkg::COEF_FRAC);
         wide_bp = scale_round(bp * four_r, svf_pkg::COEF_FRAC);
         band_state = clip(g_hp + bp, svf_pkg::ACC_W);
         low_state = clip(g_bp + lp, svf_pkg::ACC_W);
         r.lowpass = SAMPLE_W'(clip(lp, SAMPLE_W));
         r.highpass = SAMPLE_W'(clip(hp, SAMPLE_W));
         r.bandpass = SAMPLE_W'(clip(ubp, SAMPLE_W));
         r.allpass = SAMPLE_W'(clip(x - wide_bp, SAMPLE_W));
         r.notch = SAMPLE_W'(clip(x - ubp, SAMPLE_W));
         r.peak = SAMPLE_W'(clip(lp - hp, SAMPLE_W));
         pending.push_back(r);
         samples_taken++;
      endfunction

      function void compare_field(string name, logic signed [SAMPLE_W-1:0] want,
                                  logic signed [SAMPLE_W-1:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(filter_response_type got);
         filter_response_type want;
         if (pending.size() == 0) begin
            $error("response beat with none outstanding");
            mismatches++;
            return;
         end
         want = pending.pop_front();
         responses_checked++;
         compare_field("lowpass_out", want.lowpass, got.lowpass);
         compare_field("highpass_out", want.highpass, got.highpass);
         compare_field("bandpass_out", want.bandpass, got.bandpass);
         compare_field("allpass_out", want.allpass, got.allpass);
         compare_field("notch_out", want.notch, got.notch);
         compare_field("peak_out", want.peak, got.peak);
      endfunction
   endclass

   logic clock;
   logic reset;

   svf_req_if #(.SAMPLE_BITS(SAMPLE_W)) req_chan();
   svf_rsp_if #(.SAMPLE_BITS(SAMPLE_W)) rsp_chan();
   svf_csr_if csr_chan();

   state_variable_filter_multimode #(.SAMPLE_BITS(SAMPLE_W)) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source),
      .csr_chan(csr_chan.sink)
   );

   svf_expected_responses book;
   bit burst_mode;
   bit long_hold_request;
   int unsigned reg_writes;
   int unsigned settings_used;

   initial begin
      clock = 1'b0;
   end

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic write_register(logic [svf_pkg::CSR_IDX_W-1:0] idx,
                                 logic [svf_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data <= value;
      do @(posedge clock); while (!csr_chan.ready);
      book.write_register(idx, value);
      reg_writes++;
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic set_coefficients(svf_pkg::gain_type g, svf_pkg::gain_type r,
                                   svf_pkg::recip_type rc);
      write_register(svf_pkg::CSR_GAIN, {1'($urandom_range(0, 1)), g});
      write_register(svf_pkg::CSR_DAMPING, {1'($urandom_range(0, 1)), r});
      write_register(svf_pkg::CSR_RECIP, rc);
      settings_used++;
   endtask

   task automatic send_sample(logic signed [SAMPLE_W-1:0] sample);
      int gap;
      gap = burst_mode ? 0 : int'($urandom_range(0, 7));
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.audio_in <= sample;
      do @(posedge clock); while (!req_chan.ready);
      book.accept_sample(sample);
   endtask

   task automatic drain();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (book.pending.size() != 0) @(posedge clock);
   endtask

   // response side: random stalls, plus one long hold when requested
   initial begin
      int stall;
      filter_response_type got;
      rsp_chan.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall = burst_mode ? 0 : int'($urandom_range(0, 7));
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            stall = LONG_HOLD_CYCLES;
         end
         @(negedge clock);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         got.lowpass = rsp_chan.lowpass_out;
         got.highpass = rsp_chan.highpass_out;
         got.bandpass = rsp_chan.bandpass_out;
         got.allpass = rsp_chan.allpass_out;
         got.notch = rsp_chan.notch_out;
         got.peak = rsp_chan.peak_out;
         book.check_response(got);
      end
   end

   initial begin
      #1_200_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      logic signed [SAMPLE_W-1:0] sample;
      svf_pkg::gain_type g;
      svf_pkg::gain_type r;
      svf_pkg::recip_type rc;
      real gr;
      real rr;
      book = new();
      burst_mode = 1'b0;
      long_hold_request = 1'b0;
      reg_writes = 0;
      settings_used = 1;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.audio_in = '0;
      csr_chan.valid = 1'b0;
      csr_chan.index = svf_pkg::CSR_GAIN;
      csr_chan.data = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset coefficients: step and full-scale inputs
      send_sample('0);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MIN);
      send_sample(24'sd1);
      send_sample(-24'sd1);
      send_sample('0);
      drain();

      // all coefficients at maximum, recip above unity: internal saturation
      set_coefficients(GAIN_MAX, GAIN_MAX, RECIP_MAX);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
      send_sample(24'sd12345);
      drain();

      // all coefficients zero; unmapped index must be ignored
      set_coefficients('0, '0, '0);
      write_register(CSR_UNMAPPED, svf_pkg::CSR_DATA_W'($urandom));
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
      send_sample('0);
      drain();

      // g = 1.0, R = 0.5, recip exactly 1.0
      set_coefficients(24'h10_0000, 24'h08_0000, RECIP_ONE);
      send_sample(SAMPLE_MAX);
      send_sample(-24'sd4096);
      send_sample(SAMPLE_MIN);
      send_sample(24'sd1);
      drain();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if ($urandom_range(0, 9) < 7) begin
            g = svf_pkg::gain_type'($urandom_range(10486, 3145728));
            r = svf_pkg::gain_type'($urandom_range(20971, 2097152));
            gr = real'(g) / 1048576.0;
            rr = real'(r) / 1048576.0;
            rc = svf_pkg::recip_type'($rtoi(16777216.0 / (1.0 + 2.0 * rr * gr + gr * gr)
                                             + 0.5));
         end else begin
            case ($urandom_range(0, 2))
               0: g = '0;
               1: g = GAIN_MAX;
               default: g = svf_pkg::gain_type'($urandom);
            endcase
            case ($urandom_range(0, 2))
               0: r = '0;
               1: r = GAIN_MAX;
               default: r = svf_pkg::gain_type'($urandom);
            endcase
            case ($urandom_range(0, 2))
               0: rc = '0;
               1: rc = RECIP_MAX;
               default: rc = svf_pkg::recip_type'($urandom);
            endcase
         end
         set_coefficients(g, r, rc);
         if ($urandom_range(0, 2) == 0) begin
            write_register(CSR_UNMAPPED, svf_pkg::CSR_DATA_W'($urandom));
         end
         burst_mode = (phase % 4 == 2);
         long_hold_request = (phase == 3 || phase == 7);
         for (int n = 0; n < PHASE_BEATS; n++) begin
            case ($urandom_range(0, 19))
               12, 13, 14, 15, 16: sample = $signed(24'($urandom_range(0, 2047))) - 24'sd1024;
               17: sample = SAMPLE_MAX;
               18: sample = SAMPLE_MIN;
               19: sample = $signed(24'($urandom_range(0, 2))) - 24'sd1;
               default: sample = SAMPLE_W'($urandom);
            endcase
            send_sample(sample);
         end
         drain();
      end
      burst_mode = 1'b0;

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Filtered %0d samples, checked %0d responses of six fields each,",
               book.samples_taken, book.responses_checked);
      $display("across %0d coefficient settings with %0d register writes.",
               settings_used, reg_writes);
      if (book.mismatches == 0 && book.pending.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
